/* src/flsa_pkg.sv */
// Shared types and constants for the free-list slot allocator.
// No dependencies; imported by every module of the block except flsa_ram.
package flsa_pkg;

   localparam int SLOT_W        = 10;    // slot_index / granted_slot width
   localparam int DATA_W        = 16;    // tdata width, whole bytes
   localparam int NUM_SLOTS_DEF = 1024;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;   // write one reset link during the clearing pass
      logic accept;       // input transfer this cycle
      logic pop_finish;   // link read data is back, move the head
   } flsa_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;   // clearing pass writes its final entry
      logic alloc_hit;    // current item is an allocate on a non-empty list
   } flsa_stat_type;

endpackage

/* src/flsa_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module flsa_ram #(
   parameter int WIDTH  = 11,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/flsa_ctrl.sv */
// Controller of the slot allocator: clearing pass, accept and pop sequencing,
// result valid. Depends on flsa_pkg.
module flsa_ctrl
   import flsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  flsa_stat_type stat,
   output flsa_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.accept     = req_tready && req_tvalid;
      cmd.pop_finish = (state_ff == ST_READ);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.accept && stat.alloc_hit) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // A pop raises result valid from the ST_READ state; everything else raises it directly at the accept.
   always_comb begin
      if (cmd.pop_finish) begin
         rsp_valid_in = 1'b1;
      end else if (cmd.accept && !stat.alloc_hit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* src/flsa_datapath.sv */
// Datapath of the slot allocator: head register, link RAM, clear counter and
// result registers. Depends on flsa_pkg and flsa_ram.
module flsa_datapath
   import flsa_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  flsa_cmd_type      cmd,
   input  logic              req_cmd,
   input  logic [SLOT_W-1:0] req_slot_index,
   output flsa_stat_type     stat,
   output logic              rsp_granted,
   output logic [SLOT_W-1:0] rsp_granted_slot,
   output logic              rsp_exhausted
);

   localparam int AW = $clog2(NUM_SLOTS);
   localparam int LW = $clog2(NUM_SLOTS + 1);
   localparam int CW = (LW > SLOT_W) ? LW : SLOT_W;

   logic [LW-1:0]     head_ff, head_in;
   logic [AW-1:0]     clear_cnt_ff, clear_cnt_in;
   logic              granted_ff;
   logic [SLOT_W-1:0] granted_slot_ff;
   logic              exhausted_ff;

   logic [CW-1:0] idx_ext;
   logic [CW-1:0] head_ext;
   logic          head_valid;
   logic          is_release;
   logic          idx_in_range;
   logic          push;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [LW-1:0] ram_wdata;
   logic [LW-1:0] ram_rdata;

   assign idx_ext      = CW'(req_slot_index);
   assign head_ext     = CW'(head_ff);
   assign head_valid   = head_ff < LW'(NUM_SLOTS);
   assign is_release   = (req_cmd == CMD_RELEASE);
   assign idx_in_range = idx_ext < CW'(NUM_SLOTS);
   assign push         = cmd.accept && is_release && idx_in_range;

   always_comb begin
      stat.clear_last = (clear_cnt_ff == AW'(NUM_SLOTS - 1));
      stat.alloc_hit  = !is_release && head_valid;
   end

   // Clearing pass writes entry i with i + 1; a push links the slot to the old head.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clear_cnt_ff;
      ram_wdata = LW'({1'b0, clear_cnt_ff} + 1'b1);
      if (cmd.clear_step) begin
         ram_we = 1'b1;
      end else if (push) begin
         ram_we    = 1'b1;
         ram_waddr = idx_ext[AW-1:0];
         ram_wdata = head_ff;
      end
   end

   // Read port always looks at the head; data is valid the cycle after accept.
   flsa_ram #(
      .WIDTH  (LW),
      .DEPTH  (NUM_SLOTS),
      .ADDR_W (AW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (head_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   always_comb begin
      head_in = head_ff;
      if (push) begin
         head_in = idx_ext[LW-1:0];
      end else if (cmd.pop_finish) begin
         head_in = ram_rdata;
      end
   end

   always_comb begin
      clear_cnt_in = clear_cnt_ff;
      if (cmd.clear_step && !stat.clear_last) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         clear_cnt_ff <= '0;
      end else begin
         head_ff      <= head_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Result fields are settled at the transfer; a pop only moves the head later.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         granted_ff      <= stat.alloc_hit;
         granted_slot_ff <= stat.alloc_hit ? head_ext[SLOT_W-1:0] : '0;
         exhausted_ff    <= !is_release && !head_valid;
      end
   end

   assign rsp_granted      = granted_ff;
   assign rsp_granted_slot = granted_slot_ff;
   assign rsp_exhausted    = exhausted_ff;

endmodule

/* src/free_list_slot_allocator.sv */
// Free-list slot allocator: LIFO linked free list over NUM_SLOTS slots.
// Release and exhausted allocate: result valid the cycle after the transfer.
// Granted allocate: result valid after the ST_READ state (link RAM read).
// Throughput: one release per cycle if rsp_tready; ST_READ holds off input.
// Reset: synchronous; a clearing pass then writes all NUM_SLOTS link RAM
// entries (1024 by default), with req_tready low. Depends on flsa_pkg.
module free_list_slot_allocator
   import flsa_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [9:0] slot_index, [15:10] zero
   input  logic              req_tuser,   // [0] cmd
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [9:0] granted_slot, [15:10] zero
   output logic [1:0]        rsp_tuser    // [0] granted, [1] exhausted
);

   flsa_cmd_type      cmd;
   flsa_stat_type     stat;
   logic              granted;
   logic              exhausted;
   logic [SLOT_W-1:0] granted_slot;

   flsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   flsa_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_cmd          (req_tuser),
      .req_slot_index   (req_tdata[SLOT_W-1:0]),
      .stat             (stat),
      .rsp_granted      (granted),
      .rsp_granted_slot (granted_slot),
      .rsp_exhausted    (exhausted)
   );

   assign rsp_tdata = DATA_W'(granted_slot);
   assign rsp_tuser = {exhausted, granted};

   // A release answers on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_RELEASE) |=> rsp_tvalid)
      else $error("release transfer without a result on the next cycle");

   // A finished pop always presents a granted result.
   assert property (@(posedge clock) disable iff (reset)
      cmd.pop_finish |=> (rsp_tvalid && rsp_tuser[0] && !rsp_tuser[1]))
      else $error("pop finished without a granted result");

   // No transfer is taken while the link RAM is being cleared.
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear_step |-> !req_tready)
      else $error("input ready during clearing pass");

endmodule

/* tb/sv/tb_free_list_slot_allocator.sv */
// Self-checking bench for free_list_slot_allocator: allocate/release traffic
// is checked against a behavioral copy of the free list kept in the bench.
// Depends on flsa_pkg and the free_list_slot_allocator RTL.
module tb_free_list_slot_allocator
   import flsa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              granted;
      logic [SLOT_W-1:0] slot;
      logic              exhausted;
   } grant_type;

   typedef struct packed {
      logic              cmd;
      logic [SLOT_W-1:0] slot_index;
      logic              typed;      // use the result below instead of the model
      grant_type         result;
   } stim_row_type;

   localparam logic [SLOT_W:0] LIST_END = (SLOT_W+1)'(NUM_SLOTS_DEF);
   localparam grant_type NO_GRANT = '{granted: 1'b0, slot: '0, exhausted: 1'b0};

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;   // [9:0] slot_index, [15:10] zero
   logic              req_tuser  = CMD_ALLOC;   // [0] cmd
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;   // [9:0] granted_slot, [15:10] zero
   logic [1:0]        rsp_tuser;   // [0] granted, [1] exhausted

   // bench copy of the free list
   logic [SLOT_W:0]   free_head_q;
   logic [SLOT_W:0]   free_link_q [NUM_SLOTS_DEF];

   grant_type         pending_grants [$];
   logic [SLOT_W-1:0] held_slots [$];
   int                mismatch_count = 0;
   int                send_idle  = 0;
   int                recv_stall = 0;
   bit                exhaust_seen = 0;

   free_list_slot_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   function automatic void clear_free_list();
      for (int i = 0; i < NUM_SLOTS_DEF; i++) free_link_q[i] = (SLOT_W+1)'(i + 1);
      free_head_q = '0;
   endfunction

   // pop or push one slot and return what the block should answer
   function automatic grant_type next_grant(input logic cmd, input logic [SLOT_W-1:0] idx);
      grant_type r;
      r = NO_GRANT;
      if (cmd == CMD_ALLOC) begin
         if (free_head_q >= LIST_END) begin
            r.exhausted = 1'b1;
         end else begin
            r.granted   = 1'b1;
            r.slot      = free_head_q[SLOT_W-1:0];
            free_head_q = free_link_q[free_head_q[SLOT_W-1:0]];
         end
      end else if (idx < NUM_SLOTS_DEF) begin
         free_link_q[idx] = free_head_q;
         free_head_q      = {1'b0, idx};
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // one input transfer; called at a rising edge, returns at the accepting edge
   task automatic send_item(input logic cmd, input logic [SLOT_W-1:0] idx,
                            input bit typed, input grant_type typed_result);
      grant_type r;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(DATA_W-SLOT_W){1'b0}}, idx};
      do @(posedge clock); while (!req_tready);
      r = next_grant(cmd, idx);
      pending_grants.insert(pending_grants.size(), typed ? typed_result : r);
      if (r.granted) held_slots.insert(held_slots.size(), r.slot);
      if (r.exhausted) exhaust_seen = 1;
      if (cmd == CMD_RELEASE) begin
         for (int i = 0; i < held_slots.size(); i++) begin
            if (held_slots[i] == idx) begin
               held_slots.delete(i);
               break;
            end
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      grant_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("result with nothing pending", int'(rsp_tdata), 0);
         end else begin
            want = pending_grants.pop_front();
            if (rsp_tuser[0] !== want.granted)
               report_mismatch("granted", int'(rsp_tuser[0]), int'(want.granted));
            if (rsp_tdata[SLOT_W-1:0] !== want.slot)
               report_mismatch("granted_slot", int'(rsp_tdata[SLOT_W-1:0]),
                               int'(want.slot));
            if (rsp_tuser[1] !== want.exhausted)
               report_mismatch("exhausted", int'(rsp_tuser[1]), int'(want.exhausted));
         end
      end
   end

   initial begin
      stim_row_type      directed [15];
      logic              cmd;
      logic [SLOT_W-1:0] idx;
      int                roll;
      int                pick;
      int                rand_count;
      int                after_exhaust;

      // fresh list hands out slots in order; releases answer all zeros
      directed = '{
         '{CMD_ALLOC,   10'h3FF, 1'b1, '{1'b1, 10'd0, 1'b0}},
         '{CMD_ALLOC,   10'h000, 1'b1, '{1'b1, 10'd1, 1'b0}},
         '{CMD_ALLOC,   10'h2AA, 1'b1, '{1'b1, 10'd2, 1'b0}},
         '{CMD_RELEASE, 10'd0,   1'b1, NO_GRANT},
         '{CMD_RELEASE, 10'd2,   1'b1, NO_GRANT},
         '{CMD_ALLOC,   10'h155, 1'b0, NO_GRANT},
         '{CMD_ALLOC,   10'h3FF, 1'b0, NO_GRANT},
         '{CMD_ALLOC,   10'h000, 1'b0, NO_GRANT},
         '{CMD_RELEASE, 10'd1,   1'b1, NO_GRANT},
         '{CMD_RELEASE, 10'd3,   1'b1, NO_GRANT},
         '{CMD_ALLOC,   10'h200, 1'b0, NO_GRANT},
         '{CMD_ALLOC,   10'h1FF, 1'b0, NO_GRANT},
         '{CMD_RELEASE, 10'd0,   1'b0, NO_GRANT},
         '{CMD_ALLOC,   10'h001, 1'b0, NO_GRANT},
         '{CMD_ALLOC,   10'h3FE, 1'b0, NO_GRANT}
      };

      clear_free_list();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_item(directed[i].cmd, directed[i].slot_index, directed[i].typed,
                   directed[i].result);

      // drain to exhaustion, mix around empty, with some bogus releases late in the run
      rand_count    = 0;
      after_exhaust = 0;
      while (!(exhaust_seen && after_exhaust >= 400)) begin
         case ((rand_count / 100) % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 48; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 48; end
            default: begin send_idle = 37; recv_stall = 37; end
         endcase
         roll = $urandom_range(99);
         idx  = SLOT_W'($urandom_range(NUM_SLOTS_DEF - 1));
         if (!exhaust_seen)
            cmd = (roll < 94 || held_slots.size() == 0) ? CMD_ALLOC : CMD_RELEASE;
         else
            cmd = (roll < 50 || held_slots.size() == 0) ? CMD_ALLOC : CMD_RELEASE;
         // late in the run, let some releases hit free slots (double release)
         if (cmd == CMD_RELEASE && !(after_exhaust >= 250 && roll >= 85)) begin
            pick = $urandom_range(held_slots.size() - 1);
            idx  = held_slots[pick];
         end
         send_item(cmd, idx, 1'b0, NO_GRANT);
         rand_count++;
         if (exhaust_seen) after_exhaust++;
      end
      req_tvalid <= 1'b0;

      while (pending_grants.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* free_list_slot_allocator.f */
src/flsa_pkg.sv
src/flsa_ram.sv
src/flsa_ctrl.sv
src/flsa_datapath.sv
src/free_list_slot_allocator.sv
tb/sv/tb_free_list_slot_allocator.sv
